@@ rtl/piecewise_linear_rate_limiter_top_defines.svh @@
// Assertion macros shared by the limiter RTL.
`ifndef PIECEWISE_LINEAR_RATE_LIMITER_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_RATE_LIMITER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/plr_pkg.sv @@
// Types and constants of the piecewise-linear rate limiter.
package plr_pkg;

  localparam int unsigned KeyW   = 24;
  localparam int unsigned ValW   = 20;
  localparam int unsigned LenW   = 32;
  localparam int unsigned ProdW  = KeyW + ValW;  // interpolation numerator
  localparam int unsigned MkeyW  = LenW + KeyW;  // mass key product
  localparam int unsigned DivStepW = 5;
  localparam logic [DivStepW-1:0] DivSteps = 5'd20;  // quotient < 2^ValW
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned InDataW  = 184;
  localparam int unsigned OutDataW = 40;

  localparam logic ActAppend = 1'b0;
  localparam logic ActQuery  = 1'b1;
  localparam logic TblMass   = 1'b0;
  localparam logic TblHeight = 1'b1;

  localparam logic [CfgIdxW-1:0] RegMassEn   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeightEn = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMassFac  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInitSpd  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInitAcc  = 3'd4;

  typedef struct packed {
    logic [KeyW-1:0] key_lo;
    logic [KeyW-1:0] key_hi;
    logic [ValW-1:0] spd_start;
    logic [ValW-1:0] spd_end;
    logic [ValW-1:0] acc_start;
    logic [ValW-1:0] acc_end;
  } seg_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_MKEY,
    ST_TSEL,
    ST_RD,
    ST_RDW,
    ST_SEG,
    ST_DIVGO,
    ST_DIVW,
    ST_DONE
  } state_e;

endpackage

@@ rtl/plr_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit ValW bits.
module plr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  plr_pkg::div_ctl_t             ctl_i,   // start used
  output plr_pkg::div_ctl_t             ctl_o,   // done used
  input  logic [plr_pkg::ProdW-1:0]     num_i,
  input  logic [plr_pkg::KeyW-1:0]      den_i,
  output logic [plr_pkg::ValW-1:0]      quo_o
);

  logic [plr_pkg::KeyW-1:0]     rem_q, rem_d;
  logic [plr_pkg::ValW-1:0]     sh_q, sh_d;
  logic [plr_pkg::KeyW-1:0]     den_q;
  logic [plr_pkg::DivStepW-1:0] cnt_q, cnt_d;
  logic                         done_q, done_d;
  logic [plr_pkg::KeyW:0]       trial;
  logic                         fits;

  assign trial = {rem_q, sh_q[plr_pkg::ValW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d = num_i[plr_pkg::ProdW-1:plr_pkg::ValW];
      sh_d  = num_i[plr_pkg::ValW-1:0];
      cnt_d = plr_pkg::DivSteps;
    end else if (cnt_q != '0) begin
      rem_d = fits ? plr_pkg::KeyW'(trial - {1'b0, den_q})
                   : trial[plr_pkg::KeyW-1:0];
      sh_d  = {sh_q[plr_pkg::ValW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == plr_pkg::DivStepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (ctl_i.start) den_q <= den_i;
  end

  assign quo_o      = sh_q;
  assign ctl_o.done = done_q;
  assign ctl_o.start = 1'b0;

endmodule

@@ rtl/piecewise_linear_rate_limiter_top.sv @@
// Piecewise-linear speed and acceleration limiter, top level.
// Two segment tables (mass-keyed and height-keyed, TABLE_ENTRIES each) live
// in one memory with a registered read port. An append request writes one
// segment unless its table is full, chaining its start values from the
// previous segment's end values or the initial-limit registers. A query
// request forms the mass key if the mass table is enabled, then walks every
// stored segment of each enabled table (mass first): each segment is read
// from memory and matched, then each quantity that needs interpolation
// passes through the single shared 20-step restoring divider.
// Running limits only ever tighten and the requested values are clamped
// by any valid nonzero limit. One request is in flight at a time; the
// result register lets the next request enter while a result waits to be
// taken.
`include "piecewise_linear_rate_limiter_top_defines.svh"

module piecewise_linear_rate_limiter_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [plr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [plr_pkg::CfgW-1:0]        cfg_data_i,
  // Request stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // key_low[23:0], key_high[47:24], speed_end[67:48], acc_end[87:68],
  // extruded_length[119:88], layer_z[143:120], requested_speed[163:144],
  // requested_acc[183:164]
  input  logic [plr_pkg::InDataW-1:0]     s_axis_tdata_i,
  // action[0], table_select[1]
  input  logic [1:0]                      s_axis_tuser_i,
  // Result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // limited_speed[19:0], limited_acc[39:20]
  output logic [plr_pkg::OutDataW-1:0]    m_axis_tdata_o,
  // status[0]
  output logic                            m_axis_tuser_o
);

  localparam int unsigned CntW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned Depth = 2 * TABLE_ENTRIES;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned KW = plr_pkg::KeyW;
  localparam int unsigned VW = plr_pkg::ValW;

  // Configuration registers
  logic          mass_en_q, height_en_q;
  logic [KW-1:0] mass_fac_q;
  logic [VW-1:0] init_spd_q, init_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_en_q   <= 1'b0;
      height_en_q <= 1'b0;
      mass_fac_q  <= '0;
      init_spd_q  <= '0;
      init_acc_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plr_pkg::RegMassEn:   mass_en_q   <= cfg_data_i[0];
        plr_pkg::RegHeightEn: height_en_q <= cfg_data_i[0];
        plr_pkg::RegMassFac:  mass_fac_q  <= cfg_data_i;
        plr_pkg::RegInitSpd:  init_spd_q  <= cfg_data_i[VW-1:0];
        plr_pkg::RegInitAcc:  init_acc_q  <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  plr_pkg::state_e state_q, state_d;

  // Latched request
  logic                     act_q, tsel_q;
  logic [KW-1:0]            klo_q, khi_q, z_q;
  logic [VW-1:0]            send_q, aend_q, rspd_q, racc_q;
  logic [plr_pkg::LenW-1:0] len_q;

  // Walk state
  logic [CntW-1:0]           cnt_q [2];
  logic [VW-1:0]             last_spd_q [2];
  logic [VW-1:0]             last_acc_q [2];
  logic                      tbl_q, qty_q, match_q, full_q;
  logic [CntW-1:0]           idx_q;
  logic [KW-1:0]             key_q;
  logic [plr_pkg::MkeyW-1:0] mprod_q;
  logic [plr_pkg::ProdW-1:0] num_q;
  logic [KW-1:0]             den_q;
  logic                      neg_q;
  logic [VW-1:0]             spd_lim_q, acc_lim_q;
  logic                      spd_vld_q, acc_vld_q;

  // Segment memory
  plr_pkg::seg_t mem [Depth];
  plr_pkg::seg_t rd_q;
  logic          mem_we;
  logic [AddrW-1:0] wr_addr, rd_addr;
  plr_pkg::seg_t wr_seg;

  // Output register
  logic                          ovld_q;
  logic [plr_pkg::OutDataW-1:0]  odata_q;
  logic                          ouser_q;
  logic                          out_load;

  // Divider
  plr_pkg::div_ctl_t div_in, div_out;
  logic [VW-1:0]     quo;

  plr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_in),
    .ctl_o  (div_out),
    .num_i  (num_q),
    .den_i  (den_q),
    .quo_o  (quo)
  );

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Current table and segment views
  logic [CntW-1:0] cur_cnt;
  logic [KW-1:0]   mkey_sat;
  logic [VW-1:0]   q_start, q_end, q_mag, new_val;
  logic            q_live;
  logic [KW-1:0]   koff;

  assign cur_cnt  = cnt_q[tbl_q];
  assign mkey_sat = (|mprod_q[plr_pkg::MkeyW-1:2*KW]) ? {KW{1'b1}} : mprod_q[2*KW-1:KW];
  assign q_start  = qty_q ? rd_q.acc_start : rd_q.spd_start;
  assign q_end    = qty_q ? rd_q.acc_end   : rd_q.spd_end;
  assign q_live   = match_q && (q_start != q_end);
  assign q_mag    = (q_end >= q_start) ? (q_end - q_start) : (q_start - q_end);
  assign koff     = key_q - rd_q.key_lo;
  assign new_val  = neg_q ? (q_start - quo) : (q_start + quo);

  assign wr_addr = AddrW'(tsel_q ? TABLE_ENTRIES : 0) + AddrW'(cnt_q[tsel_q]);
  assign rd_addr = AddrW'(tbl_q ? TABLE_ENTRIES : 0) + AddrW'(idx_q);
  assign wr_seg.key_lo    = klo_q;
  assign wr_seg.key_hi    = khi_q;
  assign wr_seg.spd_end   = send_q;
  assign wr_seg.acc_end   = aend_q;
  assign wr_seg.spd_start = (cnt_q[tsel_q] == '0) ? init_spd_q : last_spd_q[tsel_q];
  assign wr_seg.acc_start = (cnt_q[tsel_q] == '0) ? init_acc_q : last_acc_q[tsel_q];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_seg;
    rd_q <= mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    div_in.start    = 1'b0;
    div_in.done     = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      plr_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i[0] == plr_pkg::ActAppend) state_d = plr_pkg::ST_APPEND;
          else if (mass_en_q) state_d = plr_pkg::ST_MKEY;
          else if (height_en_q) state_d = plr_pkg::ST_TSEL;
          else state_d = plr_pkg::ST_DONE;
        end
      end
      plr_pkg::ST_APPEND: begin
        mem_we  = (cnt_q[tsel_q] < CntW'(TABLE_ENTRIES));
        state_d = plr_pkg::ST_DONE;
      end
      plr_pkg::ST_MKEY: state_d = plr_pkg::ST_TSEL;
      plr_pkg::ST_TSEL: state_d = plr_pkg::ST_RD;
      plr_pkg::ST_RD: begin
        if (idx_q >= cur_cnt) begin
          if (tbl_q == plr_pkg::TblMass && height_en_q) state_d = plr_pkg::ST_TSEL;
          else state_d = plr_pkg::ST_DONE;
        end else begin
          state_d = plr_pkg::ST_RDW;
        end
      end
      plr_pkg::ST_RDW: state_d = plr_pkg::ST_SEG;
      plr_pkg::ST_SEG: begin
        if (q_live) state_d = plr_pkg::ST_DIVGO;
        else if (qty_q) state_d = plr_pkg::ST_RD;
      end
      plr_pkg::ST_DIVGO: begin
        div_in.start = 1'b1;
        state_d      = plr_pkg::ST_DIVW;
      end
      plr_pkg::ST_DIVW: begin
        if (div_out.done) state_d = qty_q ? plr_pkg::ST_RD : plr_pkg::ST_SEG;
      end
      plr_pkg::ST_DONE: begin
        if (!ovld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = plr_pkg::ST_IDLE;
        end
      end
      default: state_d = plr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= plr_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  // Request latch and datapath payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      act_q  <= s_axis_tuser_i[0];
      tsel_q <= s_axis_tuser_i[1];
      klo_q  <= s_axis_tdata_i[23:0];
      khi_q  <= s_axis_tdata_i[47:24];
      send_q <= s_axis_tdata_i[67:48];
      aend_q <= s_axis_tdata_i[87:68];
      len_q  <= s_axis_tdata_i[119:88];
      z_q    <= s_axis_tdata_i[143:120];
      rspd_q <= s_axis_tdata_i[163:144];
      racc_q <= s_axis_tdata_i[183:164];
      tbl_q  <= s_axis_tuser_i[0] == plr_pkg::ActQuery && !mass_en_q;
    end
    case (state_q)
      plr_pkg::ST_APPEND: full_q <= !(cnt_q[tsel_q] < CntW'(TABLE_ENTRIES));
      plr_pkg::ST_MKEY:   mprod_q <= len_q * mass_fac_q;
      plr_pkg::ST_TSEL: begin
        key_q <= tbl_q ? z_q : mkey_sat;
        idx_q <= '0;
      end
      plr_pkg::ST_RD: begin
        if (idx_q >= cur_cnt) tbl_q <= plr_pkg::TblHeight;
      end
      plr_pkg::ST_RDW: begin
        match_q <= (key_q >= rd_q.key_lo) && (key_q <= rd_q.key_hi) &&
                   (rd_q.key_hi != rd_q.key_lo);
        qty_q   <= 1'b0;
      end
      plr_pkg::ST_SEG: begin
        num_q <= q_mag * koff;
        den_q <= rd_q.key_hi - rd_q.key_lo;
        neg_q <= q_end < q_start;
        if (!q_live) begin
          if (qty_q) idx_q <= idx_q + 1'b1;
          qty_q <= 1'b1;
        end
      end
      plr_pkg::ST_DIVW: begin
        if (div_out.done) begin
          if (qty_q) idx_q <= idx_q + 1'b1;
          qty_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Table counts, chain values and running limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      spd_vld_q <= 1'b0;
      acc_vld_q <= 1'b0;
      spd_lim_q <= '0;
      acc_lim_q <= '0;
    end else begin
      if (mem_we) cnt_q[tsel_q] <= cnt_q[tsel_q] + 1'b1;
      if (state_q == plr_pkg::ST_DIVW && div_out.done) begin
        if (!qty_q && (!spd_vld_q || new_val < spd_lim_q)) begin
          spd_lim_q <= new_val;
          spd_vld_q <= 1'b1;
        end
        if (qty_q && (!acc_vld_q || new_val < acc_lim_q)) begin
          acc_lim_q <= new_val;
          acc_vld_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      last_spd_q[tsel_q] <= send_q;
      last_acc_q[tsel_q] <= aend_q;
    end
  end

  // Result formation and output register
  logic [VW-1:0] out_spd, out_acc;

  always_comb begin
    out_spd = rspd_q;
    out_acc = racc_q;
    if (act_q == plr_pkg::ActAppend) begin
      out_spd = '0;
      out_acc = '0;
    end else if (mass_en_q || height_en_q) begin
      if (spd_vld_q && spd_lim_q != '0 && spd_lim_q < rspd_q) out_spd = spd_lim_q;
      if (acc_vld_q && acc_lim_q != '0 && acc_lim_q < racc_q) out_acc = acc_lim_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (out_load) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      odata_q <= {out_acc, out_spd};
      ouser_q <= (act_q == plr_pkg::ActAppend) && full_q;
    end
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

  `PLR_ASSERT(a_div_done_waited, div_out.done |-> state_q == plr_pkg::ST_DIVW, "divider done outside wait")
  `PLR_ASSERT(a_accept_leaves_idle, s_acc |=> state_q != plr_pkg::ST_IDLE, "request accepted but idle")
  `PLR_ASSERT_ALWAYS(a_mass_cnt_bound, cnt_q[0] <= CntW'(TABLE_ENTRIES), "mass count overflow")
  `PLR_ASSERT(a_reject_zero, ovld_q && ouser_q |-> odata_q == '0, "rejected append has data")

endmodule
